>>> design/lfna_pkg.sv
// package for the lowest free number allocator
// holds the opcode type, field widths, holder count constants and capacity default; no dependencies
`default_nettype none

package lfna_pkg;

  localparam int unsigned IdCapacityDefault = 64;
  localparam int unsigned NumW              = 7;
  localparam int unsigned CountW            = 8;
  localparam logic [CountW-1:0] CountMax    = 8'd255;
  localparam logic [CountW-1:0] CountOpen   = 8'd2;

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

endpackage

`default_nettype wire

>>> design/lfna_if.sv
// request and response channel interfaces of the allocator
// valid/ready handshake with payload; depends on lfna_pkg
`default_nettype none

interface lfna_req_if;
  logic                      valid;
  logic                      ready;
  lfna_pkg::op_e             opcode;
  logic                      name_taken;
  logic [lfna_pkg::NumW-1:0] release_number;

  modport source (output valid, opcode, name_taken, release_number, input ready);
  modport sink   (input valid, opcode, name_taken, release_number, output ready);
endinterface

interface lfna_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lfna_pkg::NumW-1:0] assigned_number;
  logic                      no_free;
  logic                      group_empty;

  modport source (output valid, assigned_number, no_free, group_empty, input ready);
  modport sink   (input valid, assigned_number, no_free, group_empty, output ready);
endinterface

`default_nettype wire

>>> design/lfna_ffz.sv
// find-first-zero over the used-number bitmap
// isolates the lowest clear bit and encodes its index; depends on lfna_pkg
`default_nettype none

module lfna_ffz #(
  parameter int unsigned ID_CAPACITY = lfna_pkg::IdCapacityDefault,
  localparam int unsigned IdxW       = $clog2(ID_CAPACITY)
) (
  input  wire logic [ID_CAPACITY-1:0] map_i,
  output logic                        found_o,
  output logic [IdxW-1:0]             index_o
);
  import lfna_pkg::*;

  logic [ID_CAPACITY-1:0] free_bits;
  logic [ID_CAPACITY-1:0] lowest;

  assign free_bits = ~map_i;
  assign lowest    = free_bits & (~free_bits + ID_CAPACITY'(1));
  assign found_o   = |free_bits;

  always_comb begin
    index_o = '0;
    for (int unsigned b = 0; b < IdxW; b++) begin
      for (int unsigned k = 0; k < ID_CAPACITY; k++) begin
        if (((k >> b) & 1) == 1) begin
          index_o[b] = index_o[b] | lowest[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/lowest_free_number_allocator.sv
// Lowest free number allocator for one name group.
// Requests arrive on req_i (acquire or release), one response per request
// leaves on rsp_o, in order. Both channels use valid/ready; a word moves on
// a rising edge with valid and ready high.
// A request is captured in an input register; once the response register
// is free or being taken, the bitmap search, map/count update and response
// register load happen together, and the response leaves from that register.
// Throughput: one request per cycle while rsp_o.ready is high, as the bitmap
// and holder count are read, modified and written back together.
// When the receiver stalls, the response register holds and the captured
// request waits; req_i.ready drops once both are full and returns as soon
// as the response is taken.
// Reset (rst_ni low, asynchronous) clears the bitmap, the holder count and
// both valid flags; the block takes requests right after reset.
// Depends on lfna_pkg, lfna_if and lfna_ffz.
`default_nettype none

module lowest_free_number_allocator #(
  parameter int unsigned ID_CAPACITY = lfna_pkg::IdCapacityDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lfna_req_if.sink   req_i,
  lfna_rsp_if.source rsp_o
);
  import lfna_pkg::*;

  localparam int unsigned IdxW = $clog2(ID_CAPACITY);
  localparam int unsigned GrnW = IdxW + 1;

  logic                   req_valid_q;
  op_e                    req_op_q;
  logic                   req_taken_q;
  logic [NumW-1:0]        req_num_q;

  logic [ID_CAPACITY-1:0] map_q, map_d;
  logic [CountW-1:0]      cnt_q, cnt_d;

  logic                   rsp_valid_q, rsp_valid_d;
  logic [NumW-1:0]        rsp_num_q;
  logic                   rsp_full_q;
  logic                   rsp_empty_q;

  logic                   advance;
  logic                   ffz_found;
  logic [IdxW-1:0]        ffz_index;
  logic [GrnW-1:0]        granted;
  logic                   full;
  logic [CountW-1:0]      cnt_up;
  logic                   rel_ok;

  lfna_ffz #(
    .ID_CAPACITY(ID_CAPACITY)
  ) u_ffz (
    .map_i  (map_q),
    .found_o(ffz_found),
    .index_o(ffz_index)
  );

  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign cnt_up      = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);
  assign rel_ok      = (req_num_q != '0) && (32'(req_num_q) <= ID_CAPACITY);

  always_comb begin
    map_d   = map_q;
    cnt_d   = cnt_q;
    granted = '0;
    full    = 1'b0;
    if (advance) begin
      case (req_op_q)
        OP_ACQUIRE: begin
          if (cnt_q == '0) begin
            if (req_taken_q) begin
              map_d      = '0;
              map_d[1:0] = 2'b11;
              cnt_d      = CountOpen;
              granted    = GrnW'(2);
            end else begin
              granted = GrnW'(1);
            end
          end else if (!req_taken_q) begin
            map_d[0] = 1'b1;
            cnt_d    = cnt_up;
            granted  = GrnW'(1);
          end else if (ffz_found) begin
            map_d[ffz_index] = 1'b1;
            cnt_d            = cnt_up;
            granted          = GrnW'(ffz_index) + GrnW'(1);
          end else begin
            full = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (cnt_q != '0 && rel_ok) begin
            for (int unsigned k = 0; k < ID_CAPACITY; k++) begin
              if (k + 1 == 32'(req_num_q)) begin
                map_d[k] = 1'b0;
              end
            end
            cnt_d = cnt_q - CountW'(1);
            if (cnt_d == '0) begin
              map_d = '0;
            end
          end
        end
        default: begin
          map_d = map_q;
        end
      endcase
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (advance) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      map_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (req_i.ready) begin
        req_valid_q <= req_i.valid;
      end
      rsp_valid_q <= rsp_valid_d;
      map_q       <= map_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_op_q    <= req_i.opcode;
      req_taken_q <= req_i.name_taken;
      req_num_q   <= req_i.release_number;
    end
    if (advance) begin
      rsp_num_q   <= NumW'(granted);
      rsp_full_q  <= full;
      rsp_empty_q <= (cnt_d == '0);
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.assigned_number = rsp_num_q;
  assign rsp_o.no_free         = rsp_full_q;
  assign rsp_o.group_empty     = rsp_empty_q;

endmodule

`default_nettype wire

>>> design/lfna_chk.sv
// port-level checker for the allocator, bound to the top level
// watches the response channel over time; depends on lfna_pkg
`default_nettype none

module lfna_chk (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      rsp_valid_i,
  input wire logic                      rsp_ready_i,
  input wire logic [lfna_pkg::NumW-1:0] rsp_num_i,
  input wire logic                      rsp_full_i,
  input wire logic                      rsp_empty_i
);
  import lfna_pkg::*;

  // an exhausted map grants nothing
  a_full_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_full_i |-> rsp_num_i == '0)
    else $error("no_free with a nonzero number");

  // exhaustion only happens with the group open and leaves it open
  a_full_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_full_i |-> !rsp_empty_i)
    else $error("no_free with an empty group");

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_num_i)
      && $stable(rsp_full_i) && $stable(rsp_empty_i))
    else $error("response changed under stall");

endmodule

bind lowest_free_number_allocator lfna_chk u_lfna_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_num_i  (rsp_o.assigned_number),
  .rsp_full_i (rsp_o.no_free),
  .rsp_empty_i(rsp_o.group_empty)
);

`default_nettype wire
